FILE: hw/rtl/plt_pkg.sv
// plt_pkg: shared types and constants for the piecewise linear table interpolator
// no dependencies; imported by piecewise_linear_table_interp, plt_ring and plt_cell
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam int MAX_KNOTS  = 256;
    localparam int KIDX_W     = $clog2(MAX_KNOTS);
    localparam int CNT_W      = $clog2(MAX_KNOTS + 1);
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 24;
    localparam int PROD_STEPS = 32;
    localparam int DIV_STEPS  = 65;
    localparam int ITER_W     = 7;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } plt_op_t;

    typedef enum logic {
        CFG_POINTS    = 1'b0,
        CFG_TIME_STEP = 1'b1
    } plt_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TIME,
        S_SCAN,
        S_SEL,
        S_PROD,
        S_DIV,
        S_FIN,
        S_OUT
    } plt_state_t;

    // control from the sequencer to the knot ring
    typedef struct packed {
        logic              shift;
        logic              wr_en;
        logic [KIDX_W-1:0] wr_idx;
    } plt_ring_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/piecewise_linear_table_interp.sv
// piecewise_linear_table_interp: knot table with linear interpolation between knots
// depends on plt_pkg and plt_ring (which uses plt_cell)
// sequence: a load writes its ring cell on the input transfer; a query runs S_TIME, S_SCAN, S_SEL,
// then S_PROD, S_DIV and S_FIN only when interpolated, and S_OUT moves the result into the output reg
// throughput: one query at a time, set by the full turn of the knot ring and, when interpolated,
// a 32-step multiply and 65-step divide; loads may follow each other every cycle while idle
// reset: synchronous active low, clears control, presets config; knot contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // item input channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_opcode,
    input  wire logic [7:0]                  s_knot_index,
    input  wire logic [plt_pkg::DATA_W-1:0]  s_knot_time,
    input  wire logic signed [plt_pkg::DATA_W-1:0] s_knot_value,
    input  wire logic [plt_pkg::STEP_W-1:0]  s_step_number,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [plt_pkg::DATA_W-1:0] m_interp_value,
    output logic                             m_time_saturated,
    // configuration write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [plt_pkg::DATA_W-1:0]  cfg_data
);
    import plt_pkg::*;

    // configuration
    logic [8:0]        points_reg;
    logic [DATA_W-1:0] time_step_reg;

    // sequencer
    plt_state_t state_reg, state_next;
    logic [KIDX_W-1:0] scan_reg;
    logic [ITER_W-1:0] iter_reg;

    // query data
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] t_reg;
    logic              sat_reg;
    logic [KIDX_W-1:0] last_idx_reg;

    // scan captures
    logic [DATA_W-1:0] first_t_reg, first_v_reg, last_t_reg, last_v_reg;
    logic [DATA_W-1:0] prev_t_reg, prev_v_reg;
    logic [DATA_W-1:0] s0_t_reg, s0_v_reg, s1_t_reg, s1_v_reg;
    logic              found_reg;

    // arithmetic
    logic [DATA_W:0]   mag_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] off_reg, len_reg, rem_reg;
    logic [64:0]       acc_reg;
    logic [DATA_W-1:0] res_reg;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_sat_reg;

    logic              in_xfer, q_xfer, ld_xfer, out_free, scan_end;
    logic [CNT_W-1:0]  n_eff;
    logic [55:0]       time_prod;
    logic [DATA_W-1:0] head_t, head_v;
    plt_ring_ctl_t     ring_ctl;
    logic [DATA_W:0]   dv;
    logic [DATA_W:0]   rem_sh;
    logic              div_ge;
    logic [DATA_W+1:0] fin_sum;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;
    assign q_xfer    = in_xfer && (s_opcode == OP_QUERY);
    assign ld_xfer   = in_xfer && (s_opcode == OP_LOAD);
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_end  = (scan_reg == KIDX_W'(MAX_KNOTS - 1));

    // knot count clamped to 1..MAX_KNOTS
    always_comb begin
        if (points_reg == 9'd0) begin
            n_eff = CNT_W'(1);
        end else if (32'(points_reg) > 32'(MAX_KNOTS)) begin
            n_eff = CNT_W'(MAX_KNOTS);
        end else begin
            n_eff = CNT_W'(points_reg);
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg    <= 9'd1;
            time_step_reg <= 32'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (plt_cfg_t'(cfg_index))
                CFG_POINTS:    points_reg    <= cfg_data[8:0];
                CFG_TIME_STEP: time_step_reg <= cfg_data;
            endcase
        end
    end

    // knot ring: loads write a cell, a query turns the ring once
    always_comb begin
        ring_ctl.shift  = (state_reg == S_SCAN);
        ring_ctl.wr_en  = ld_xfer && (32'(s_knot_index) < 32'(MAX_KNOTS));
        ring_ctl.wr_idx = KIDX_W'(s_knot_index);
    end

    plt_ring u_ring (
        .aclk       (aclk),
        .ctl        (ring_ctl),
        .wr_time    (s_knot_time),
        .wr_value   (s_knot_value),
        .head_time  (head_t),
        .head_value (head_v)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_xfer) state_next = S_TIME;
            S_TIME: state_next = S_SCAN;
            S_SCAN: if (scan_end) state_next = S_SEL;
            S_SEL: begin
                if (t_reg <= first_t_reg || t_reg >= last_t_reg || !found_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_PROD;
                end
            end
            S_PROD: if (iter_reg == ITER_W'(PROD_STEPS - 1)) state_next = S_DIV;
            S_DIV:  if (iter_reg == ITER_W'(DIV_STEPS - 1)) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            iter_reg <= '0;
        end else begin
            if (state_reg == S_SCAN) begin
                scan_reg <= scan_reg + KIDX_W'(1);
            end else begin
                scan_reg <= '0;
            end
            if ((state_reg == S_PROD && iter_reg != ITER_W'(PROD_STEPS - 1)) ||
                (state_reg == S_DIV)) begin
                iter_reg <= iter_reg + ITER_W'(1);
            end else begin
                iter_reg <= '0;
            end
        end
    end

    // time = step * time_step, saturated to 32 bits
    assign time_prod = 56'(step_reg) * 56'(time_step_reg);

    // segment difference as 33-bit signed
    assign dv = {s1_v_reg[DATA_W-1], s1_v_reg} - {s0_v_reg[DATA_W-1], s0_v_reg};

    // restoring divide step: remainder stays below len, so 33 bits cover the shift
    assign rem_sh = {rem_reg, acc_reg[64]};
    assign div_ge = (rem_sh >= {1'b0, len_reg});

    assign fin_sum = neg_reg ? {{2{s0_v_reg[DATA_W-1]}}, s0_v_reg} - {1'b0, acc_reg[DATA_W:0]}
                             : {{2{s0_v_reg[DATA_W-1]}}, s0_v_reg} + {1'b0, acc_reg[DATA_W:0]};

    // query datapath
    always_ff @(posedge aclk) begin
        if (q_xfer) begin
            step_reg     <= s_step_number;
            last_idx_reg <= KIDX_W'(n_eff - CNT_W'(1));
        end
        if (state_reg == S_TIME) begin
            sat_reg <= |time_prod[55:32];
            t_reg   <= (|time_prod[55:32]) ? '1 : time_prod[31:0];
        end
        if (state_reg == S_SCAN) begin
            if (scan_reg == '0) begin
                first_t_reg <= head_t;
                first_v_reg <= head_v;
            end
            if (scan_reg == last_idx_reg) begin
                last_t_reg <= head_t;
                last_v_reg <= head_v;
            end
            // lowest segment with prev <= t < head
            if (scan_reg != '0 && scan_reg <= last_idx_reg && !found_reg &&
                prev_t_reg <= t_reg && t_reg < head_t) begin
                s0_t_reg <= prev_t_reg;
                s0_v_reg <= prev_v_reg;
                s1_t_reg <= head_t;
                s1_v_reg <= head_v;
            end
            prev_t_reg <= head_t;
            prev_v_reg <= head_v;
        end
        if (state_reg == S_SEL) begin
            if (t_reg <= first_t_reg) begin
                res_reg <= first_v_reg;
            end else begin
                res_reg <= last_v_reg;
            end
            neg_reg <= dv[DATA_W];
            mag_reg <= dv[DATA_W] ? (~dv + (DATA_W+1)'(1)) : dv;
            off_reg <= t_reg - s0_t_reg;
            len_reg <= s1_t_reg - s0_t_reg;
            acc_reg <= '0;
            rem_reg <= '0;
        end
        if (state_reg == S_PROD) begin
            acc_reg <= {acc_reg[63:0], 1'b0} + (off_reg[DATA_W-1] ? 65'(mag_reg) : 65'd0);
            off_reg <= {off_reg[DATA_W-2:0], 1'b0};
        end
        if (state_reg == S_DIV) begin
            rem_reg <= div_ge ? DATA_W'(rem_sh - {1'b0, len_reg}) : DATA_W'(rem_sh);
            acc_reg <= {acc_reg[63:0], div_ge};
        end
        if (state_reg == S_FIN) begin
            res_reg <= fin_sum[DATA_W-1:0];
        end
    end

    // segment found flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (q_xfer) begin
            found_reg <= 1'b0;
        end else if (state_reg == S_SCAN && scan_reg != '0 && scan_reg <= last_idx_reg &&
                     prev_t_reg <= t_reg && t_reg < head_t) begin
            found_reg <= 1'b1;
        end
    end

    // output register parts the result side from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_value_reg <= res_reg;
            m_sat_reg   <= sat_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_interp_value   = m_value_reg;
    assign m_time_saturated = m_sat_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/plt_cell.sv
// plt_cell: one knot store of the ring, hands its knot to its neighbour on shift
// depends on plt_pkg
`timescale 1ns / 1ps
`default_nettype none

module plt_cell (
    input  wire logic                      aclk,
    input  wire logic                      shift,
    input  wire logic                      wr_en,
    input  wire logic [plt_pkg::DATA_W-1:0] wr_time,
    input  wire logic [plt_pkg::DATA_W-1:0] wr_value,
    input  wire logic [plt_pkg::DATA_W-1:0] nb_time,
    input  wire logic [plt_pkg::DATA_W-1:0] nb_value,
    output logic      [plt_pkg::DATA_W-1:0] knot_time,
    output logic      [plt_pkg::DATA_W-1:0] knot_value
);
    import plt_pkg::*;

    logic [DATA_W-1:0] time_reg;
    logic [DATA_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_reg  <= wr_time;
            value_reg <= wr_value;
        end else if (shift) begin
            time_reg  <= nb_time;
            value_reg <= nb_value;
        end
    end

    assign knot_time  = time_reg;
    assign knot_value = value_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/plt_ring.sv
// plt_ring: circular row of knot cells; cell 0 is the head seen by the scan
// depends on plt_pkg and plt_cell
`timescale 1ns / 1ps
`default_nettype none

module plt_ring (
    input  wire logic                        aclk,
    input  wire plt_pkg::plt_ring_ctl_t      ctl,
    input  wire logic [plt_pkg::DATA_W-1:0]  wr_time,
    input  wire logic [plt_pkg::DATA_W-1:0]  wr_value,
    output logic      [plt_pkg::DATA_W-1:0]  head_time,
    output logic      [plt_pkg::DATA_W-1:0]  head_value
);
    import plt_pkg::*;

    logic [DATA_W-1:0] c_time  [MAX_KNOTS];
    logic [DATA_W-1:0] c_value [MAX_KNOTS];

    for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
        localparam int NB = (i + 1) % MAX_KNOTS;
        plt_cell u_cell (
            .aclk       (aclk),
            .shift      (ctl.shift),
            .wr_en      (ctl.wr_en && (ctl.wr_idx == KIDX_W'(i))),
            .wr_time    (wr_time),
            .wr_value   (wr_value),
            .nb_time    (c_time[NB]),
            .nb_value   (c_value[NB]),
            .knot_time  (c_time[i]),
            .knot_value (c_value[i])
        );
    end

    assign head_time  = c_time[0];
    assign head_value = c_value[0];

endmodule

`default_nettype wire

FILE: hw/rtl/plt_checker.sv
// plt_checker: port level checks for piecewise_linear_table_interp, bound to the top level
// depends on nothing but the top level ports
`timescale 1ns / 1ps
`default_nettype none

module plt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_opcode,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_interp_value,
    input wire logic        m_time_saturated
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_interp_value) && $stable(m_time_saturated))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a query transfer makes the block busy
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode |=> !s_ready)
        else $error("query did not occupy the block");

    // a load transfer leaves the block ready
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_opcode |=> s_ready)
        else $error("load stalled the input");

endmodule

bind piecewise_linear_table_interp plt_checker u_plt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_opcode         (s_opcode),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_interp_value   (m_interp_value),
    .m_time_saturated (m_time_saturated)
);

`default_nettype wire
